// ===== rtl/ffha_pkg.sv =====
// ffha_pkg: shared types and codes for the first-fit heap allocator.
// Used by first_fit_heap_allocator and ffha_table; depends on nothing.
package ffha_pkg;

   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_FREE   = 2'd1;
   localparam logic [1:0] OP_RESIZE = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_LIMIT   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_UNKNOWN = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ROUND,
      S_ALIGN,
      S_DISPATCH,
      S_SEARCH,
      S_FIND,
      S_RSZ,
      S_RSZ_NEXT,
      S_FREE,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      TBL_NONE,
      TBL_SET_TOTAL,
      TBL_INSERT,
      TBL_REMOVE
   } tbl_op_type;

   typedef struct packed {
      tbl_op_type op;
   } tbl_cmd_type;

endpackage

// ===== rtl/ffha_table.sv =====
// ffha_table: address-ordered block table (start, total) with entry count.
// One read port; insert / remove shift the entries in place. Depends on ffha_pkg.
module ffha_table
   import ffha_pkg::*;
#(
   parameter int MAX_BLOCKS = 16,
   parameter int WW         = 28,
   parameter int HDR_TOTAL  = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tbl_cmd_type                     cmd,
   input  logic [$clog2(MAX_BLOCKS)-1:0]   wr_idx,
   input  logic [WW-1:0]                   wr_start,
   input  logic [WW-1:0]                   wr_total,
   input  logic [$clog2(MAX_BLOCKS)-1:0]   rd_idx,
   output logic [WW-1:0]                   rd_start,
   output logic [WW-1:0]                   rd_total,
   output logic [$clog2(MAX_BLOCKS+1)-1:0] count
);

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);

   logic [WW-1:0] start_ff [MAX_BLOCKS];
   logic [WW-1:0] total_ff [MAX_BLOCKS];
   logic [CW-1:0] count_ff;

   assign rd_start = start_ff[rd_idx];
   assign rd_total = total_ff[rd_idx];
   assign count    = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= CW'(1);
         start_ff[0] <= '0;
         total_ff[0] <= WW'(HDR_TOTAL);
      end else begin
         unique case (cmd.op)
            TBL_SET_TOTAL: begin
               total_ff[wr_idx] <= wr_total;
            end
            TBL_INSERT: begin
               for (int j = 1; j < MAX_BLOCKS; j++) begin
                  if (IW'(j) == wr_idx) begin
                     start_ff[j] <= wr_start;
                     total_ff[j] <= wr_total;
                  end else if (IW'(j) > wr_idx && CW'(j) <= count_ff) begin
                     start_ff[j] <= start_ff[j-1];
                     total_ff[j] <= total_ff[j-1];
                  end
               end
               count_ff <= count_ff + CW'(1);
            end
            TBL_REMOVE: begin
               for (int j = 1; j < MAX_BLOCKS - 1; j++) begin
                  if (IW'(j) >= wr_idx) begin
                     start_ff[j] <= start_ff[j+1];
                     total_ff[j] <= total_ff[j+1];
                  end
               end
               count_ff <= count_ff - CW'(1);
            end
            default: begin
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CW'(1) && count_ff <= CW'(MAX_BLOCKS))
      else $error("table count out of range");
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.op == TBL_INSERT |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow table");
   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      cmd.op == TBL_REMOVE |=> count_ff == $past(count_ff) - CW'(1))
      else $error("remove did not shrink table");
`endif

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// first_fit_heap_allocator: first-fit heap allocator, top level and sequencer.
// Instantiates ffha_table; depends on ffha_pkg.
//
//   channel | dir | transfer content
//   req     | in  | tuser operation, tdata request_size / block_address
//   rsp     | out | tuser status / copy_needed, tdata address / length / break
//   csr     | in  | heap_limit write
//
// A transfer runs alignment rounding (reciprocal multiply for a non power of two
// alignment), then a walk of the table one entry per cycle through its single
// read port, and then waits out any response stall.
// Reset is synchronous; the table holds only the sentinel afterwards.
// req_tready is low from accept until the response transfer completes.
module first_fit_heap_allocator
   import ffha_pkg::*;
#(
   parameter int MAX_BLOCKS   = 16,
   parameter int ADDR_BITS    = 20,
   parameter int ALIGN_BYTES  = 8,
   parameter int HEADER_BYTES = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [ADDR_BITS:0]                    csr_wr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // request_size, block_address
   input  logic [((2*ADDR_BITS+7)/8)*8-1:0]      req_tdata,
   // operation
   input  logic [1:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // result_address, copy_length, break_value
   output logic [((3*ADDR_BITS+1+7)/8)*8-1:0]    rsp_tdata,
   // status, copy_needed
   output logic [2:0]                            rsp_tuser
);

   localparam int IW        = $clog2(MAX_BLOCKS);
   localparam int CW        = $clog2(MAX_BLOCKS + 1);
   localparam int WW        = ADDR_BITS + 8;
   localparam int NX        = ADDR_BITS + 1;
   localparam int SH        = NX + $clog2(ALIGN_BYTES);
   localparam int RW        = $clog2(2 * ALIGN_BYTES) + 1;
   localparam int OUT_W     = ((3*ADDR_BITS+1+7)/8)*8;
   localparam int HDR_TOTAL = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam bit POW2      = (ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0;
   localparam logic [NX:0] RECIP =
      (NX+1)'(((64'd1 << SH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));
   localparam logic [WW-1:0] AMASK = WW'(ALIGN_BYTES - 1);
   localparam logic [WW-1:0] CAP   = WW'(1) << ADDR_BITS;
   localparam logic [WW-1:0] HDR   = WW'(HEADER_BYTES);

   state_type state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   logic [ADDR_BITS-1:0] size_ff, size_in, addr_ff, addr_in;
   logic [WW-1:0]        need_ff, need_in, prev_ff, prev_in;
   logic [WW-1:0]        oldt_ff, oldt_in, starti_ff, starti_in;
   logic [WW-1:0]        res_ff, res_in, clen_ff, clen_in, brk_ff, brk_in;
   logic [CW-1:0]        idx_ff, idx_in, fidx_ff, fidx_in;
   logic [1:0]           status_ff, status_in;
   logic                 copy_ff, copy_in, mv_ff, mv_in;
   logic [ADDR_BITS:0]   limit_ff;
   logic [RW-1:0]        rem_ff, rem_in;
   logic [NX-1:0]        quot_ff, quot_in, rnd_x;
   logic [2*NX:0]        prod;

   tbl_cmd_type    cmd;
   logic [IW-1:0]  wr_idx, rd_idx;
   logic [WW-1:0]  wr_start, rd_start, rd_total, lim, tsum, nb;
   logic [CW-1:0]  cnt, cnt_m1;
   logic           ins_go, alloc_go;
   logic [CW-1:0]  ins_pos;

   ffha_table #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .WW         (WW),
      .HDR_TOTAL  (HDR_TOTAL)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .wr_idx   (wr_idx),
      .wr_start (wr_start),
      .wr_total (need_ff),
      .rd_idx   (rd_idx),
      .rd_start (rd_start),
      .rd_total (rd_total),
      .count    (cnt)
   );

   assign cnt_m1 = cnt - CW'(1);
   assign lim    = (WW'(limit_ff) < CAP) ? WW'(limit_ff) : CAP;
   assign tsum   = WW'(size_ff) + HDR;
   assign nb     = brk_ff - oldt_ff + need_ff;
   // rounded-up quotient by the alignment
   assign rnd_x  = NX'(tsum + WW'(ALIGN_BYTES - 1));
   assign prod   = (2*NX+1)'(rnd_x) * (2*NX+1)'(RECIP);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = OUT_W'({brk_ff[ADDR_BITS:0], clen_ff[ADDR_BITS-1:0],
                               res_ff[ADDR_BITS-1:0]});
   assign rsp_tuser  = {copy_ff, status_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         brk_ff   <= WW'(HDR_TOTAL);
         limit_ff <= (ADDR_BITS+1)'(1) << ADDR_BITS;
      end else begin
         state_ff <= state_in;
         brk_ff   <= brk_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
      op_ff     <= op_in;
      size_ff   <= size_in;
      addr_ff   <= addr_in;
      need_ff   <= need_in;
      prev_ff   <= prev_in;
      oldt_ff   <= oldt_in;
      starti_ff <= starti_in;
      res_ff    <= res_in;
      clen_ff   <= clen_in;
      idx_ff    <= idx_in;
      fidx_ff   <= fidx_in;
      status_ff <= status_in;
      copy_ff   <= copy_in;
      mv_ff     <= mv_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      size_in   = size_ff;
      addr_in   = addr_ff;
      need_in   = need_ff;
      prev_in   = prev_ff;
      oldt_in   = oldt_ff;
      starti_in = starti_ff;
      res_in    = res_ff;
      clen_in   = clen_ff;
      brk_in    = brk_ff;
      idx_in    = idx_ff;
      fidx_in   = fidx_ff;
      status_in = status_ff;
      copy_in   = copy_ff;
      mv_in     = mv_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      cmd.op    = TBL_NONE;
      wr_idx    = fidx_ff[IW-1:0];
      wr_start  = prev_ff;
      rd_idx    = idx_ff[IW-1:0];
      ins_go    = 1'b0;
      ins_pos   = idx_ff;
      alloc_go  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               size_in   = req_tdata[ADDR_BITS-1:0];
               addr_in   = req_tdata[2*ADDR_BITS-1:ADDR_BITS];
               res_in    = '0;
               clen_in   = '0;
               status_in = ST_OK;
               copy_in   = 1'b0;
               mv_in     = 1'b0;
               rem_in    = '0;
               state_in  = S_ROUND;
            end
         end
         S_ROUND: begin
            if (POW2) begin
               rem_in = RW'(tsum & AMASK);
            end else begin
               quot_in = NX'(prod >> SH);
            end
            state_in = S_ALIGN;
         end
         S_ALIGN: begin
            if (POW2) begin
               need_in = (rem_ff != '0) ? tsum + WW'(ALIGN_BYTES) - WW'(rem_ff) : tsum;
            end else begin
               need_in = WW'(quot_ff) * WW'(ALIGN_BYTES);
            end
            state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (op_ff == OP_ALLOC || (op_ff == OP_RESIZE && addr_ff == '0)) begin
               alloc_go = 1'b1;
            end else if (op_ff == OP_FREE || op_ff == OP_RESIZE) begin
               if (addr_ff == '0) begin
                  state_in = S_RESP;
               end else begin
                  idx_in   = CW'(1);
                  state_in = S_FIND;
               end
            end else begin
               state_in = S_RESP;
            end
         end
         S_SEARCH: begin
            if (idx_ff == cnt) begin
               if (brk_ff + need_ff > lim) begin
                  status_in = ST_LIMIT;
                  state_in  = S_RESP;
               end else begin
                  ins_go   = 1'b1;
                  ins_pos  = cnt;
                  wr_start = brk_ff;
                  res_in   = brk_ff + HDR;
                  brk_in   = brk_ff + need_ff;
               end
            end else if (idx_ff == '0) begin
               prev_in = rd_start + rd_total;
               idx_in  = idx_ff + CW'(1);
            end else if (prev_ff <= rd_start && rd_start - prev_ff >= need_ff) begin
               ins_go = 1'b1;
               res_in = prev_ff + HDR;
            end else begin
               prev_in = rd_start + rd_total;
               idx_in  = idx_ff + CW'(1);
            end
         end
         S_FIND: begin
            if (idx_ff == cnt) begin
               status_in = ST_UNKNOWN;
               state_in  = S_RESP;
            end else if (rd_start + HDR == WW'(addr_ff)) begin
               fidx_in   = idx_ff;
               oldt_in   = rd_total;
               starti_in = rd_start;
               state_in  = (op_ff == OP_RESIZE && size_ff != '0) ? S_RSZ : S_FREE;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_RSZ: begin
            if (need_ff == oldt_ff) begin
               res_in   = WW'(addr_ff);
               state_in = S_RESP;
            end else if (fidx_ff == cnt_m1) begin
               if (need_ff > oldt_ff && nb > lim) begin
                  status_in = ST_LIMIT;
               end else begin
                  cmd.op = TBL_SET_TOTAL;
                  brk_in = nb;
                  res_in = WW'(addr_ff);
               end
               state_in = S_RESP;
            end else if (need_ff < oldt_ff) begin
               cmd.op   = TBL_SET_TOTAL;
               res_in   = WW'(addr_ff);
               state_in = S_RESP;
            end else begin
               state_in = S_RSZ_NEXT;
            end
         end
         S_RSZ_NEXT: begin
            rd_idx = IW'(fidx_ff + CW'(1));
            if (starti_ff + need_ff <= rd_start) begin
               cmd.op   = TBL_SET_TOTAL;
               res_in   = WW'(addr_ff);
               state_in = S_RESP;
            end else begin
               mv_in    = 1'b1;
               alloc_go = 1'b1;
            end
         end
         S_FREE: begin
            if (fidx_ff == cnt_m1) begin
               brk_in = (oldt_ff <= brk_ff) ? brk_ff - oldt_ff : '0;
            end
            cmd.op   = TBL_REMOVE;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (alloc_go) begin
         if (size_ff == '0) begin
            state_in = S_RESP;
         end else if (cnt >= CW'(MAX_BLOCKS)) begin
            status_in = ST_FULL;
            state_in  = S_RESP;
         end else begin
            idx_in   = '0;
            state_in = S_SEARCH;
         end
      end

      if (ins_go) begin
         cmd.op = TBL_INSERT;
         wr_idx = ins_pos[IW-1:0];
         if (mv_ff) begin
            copy_in  = 1'b1;
            clen_in  = oldt_ff - HDR;
            fidx_in  = (ins_pos <= fidx_ff) ? fidx_ff + CW'(1) : fidx_ff;
            state_in = S_FREE;
         end else begin
            state_in = S_RESP;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_break_cap: assert property (@(posedge clock) disable iff (reset)
      brk_ff <= CAP)
      else $error("break beyond address space");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_ROUND)
      else $error("accepted transfer did not start");
   a_copy_moved: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && copy_ff |-> status_ff == ST_OK && op_ff == OP_RESIZE)
      else $error("copy flagged outside a moving resize");
`endif

endmodule
